[sv/whist_pkg.sv]
package whist_pkg;

    localparam int NBINS     = 64;
    localparam int BIN_W     = $clog2(NBINS);
    localparam int SLOT_W    = 7;
    localparam int EDGE_AW   = $clog2(NBINS + 1);
    localparam int POS_W     = 32;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int STAT_W    = CNT_W + SUM_W;
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 34;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SLOT_W-1:0] BINS_RESET = SLOT_W'(NBINS);
    localparam logic [SUM_W-1:0]  SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]  SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

    localparam logic [1:0] MODE_AVG  = 2'd0;
    localparam logic [1:0] MODE_DENS = 2'd1;

    localparam logic REG_BINS = 1'b0;
    localparam logic REG_MODE = 1'b1;

    typedef enum logic [1:0] {
        REQ_EDGE   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_BAD    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_MISS   = 2'd1,
        STS_RANGE  = 2'd2,
        STS_ZERO_W = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_HIT_RD,
        FSM_HIT_WB,
        FSM_RD_LO,
        FSM_RD_HI,
        FSM_CALC,
        FSM_DIV,
        FSM_RESP
    } fsm_t;

endpackage

[sv/weighted_histogram_1d.sv]
// edge write or rejected request: IDLE, then RESP, then the output register
// add sample: SCAN reads the edge ram one edge per cycle, then HIT_RD and HIT_WB on a hit, then RESP
// read: RD_LO, RD_HI, CALC, then RESP, with DIV before RESP when the 64-step serial divider runs
// one item at a time; the next item is taken while the last result waits in the output register
// reset: counts and sums read as zero (per-bin valid flags), edges undefined until written,
// bins_in_use 64, value_mode 0
module weighted_histogram_1d
    import whist_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // slot_index[6:0], position[38:7], sample_weight[70:39]
    input  logic [1:0]   s_tuser,  // req_type[1:0]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,  // bin_number[5:0], bin_center[37:6], bin_count[69:38],
                                   // bin_weight_sum[117:70], bin_value[165:118]
    output logic [1:0]   m_tuser   // status[1:0]
);

    fsm_t state_reg, state_next;

    logic [SLOT_W-1:0] bins_reg, bins_next;
    logic [1:0]        mode_reg, mode_next;
    logic [SLOT_W-1:0] nb;
    logic              cfg_wr;

    logic [SLOT_W-1:0] in_slot;
    logic [POS_W-1:0]  in_pos;
    logic [POS_W-1:0]  in_wt;
    logic [1:0]        in_req;

    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   wt_reg, wt_next;
    logic [EDGE_AW-1:0] idx_reg, idx_next;
    logic               dval_reg, dval_next;
    logic [EDGE_AW-1:0] didx_reg, didx_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [NBINS-1:0]   valid_reg, valid_next;

    logic [1:0]       res_status_reg, res_status_next;
    logic [BIN_W-1:0] res_num_reg, res_num_next;
    logic [POS_W-1:0] res_center_reg, res_center_next;
    logic [CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic [SUM_W-1:0] res_sum_reg, res_sum_next;
    logic [SUM_W-1:0] res_val_reg, res_val_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [BIN_W-1:0] m_num_reg, m_num_next;
    logic [POS_W-1:0] m_center_reg, m_center_next;
    logic [CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic [SUM_W-1:0] m_sum_reg, m_sum_next;
    logic [SUM_W-1:0] m_val_reg, m_val_next;

    logic               edge_we;
    logic [EDGE_AW-1:0] edge_addr;
    logic [POS_W-1:0]   edge_wdata, edge_rdata;
    logic               stat_we;
    logic [BIN_W-1:0]   stat_addr;
    logic [STAT_W-1:0]  stat_wdata, stat_rdata;
    logic [CNT_W-1:0]   old_cnt;
    logic [SUM_W-1:0]   old_sum;
    logic [CNT_W-1:0]   new_cnt;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   new_sum;

    logic [POS_W:0]     center_ext;
    logic [POS_W:0]     width_ext;
    logic [DIV_N_W-1:0] num_s;
    logic [DIV_D_W-1:0] den_s;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic               quot_neg;
    logic               div_start;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quot;
    logic [SUM_W-1:0]   quot_sat;
    logic               scan_hit;

    assign in_slot = s_tdata[6:0];
    assign in_pos  = s_tdata[38:7];
    assign in_wt   = s_tdata[70:39];
    assign in_req  = s_tuser;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        bins_next = bins_reg;
        mode_next = mode_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_BINS)
            begin
                bins_next = pwdata[SLOT_W-1:0];
            end
            else
            begin
                mode_next = pwdata[1:0];
            end
        end
        if (paddr[2] == REG_MODE)
        begin
            prdata = {30'd0, mode_reg};
        end
        else
        begin
            prdata = {{(32-SLOT_W){1'b0}}, bins_reg};
        end
    end

    // effective bin count
    always_comb
    begin
        if (bins_reg == '0)
        begin
            nb = SLOT_W'(1);
        end
        else if (bins_reg > SLOT_W'(NBINS))
        begin
            nb = SLOT_W'(NBINS);
        end
        else
        begin
            nb = bins_reg;
        end
    end

    // edge table and per-bin statistics
    whist_ram #(.WIDTH(POS_W), .DEPTH(NBINS + 1)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .addr  (edge_addr),
        .wdata (edge_wdata),
        .rdata (edge_rdata)
    );

    whist_ram #(.WIDTH(STAT_W), .DEPTH(NBINS)) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .addr  (stat_addr),
        .wdata (stat_wdata),
        .rdata (stat_rdata)
    );

    whist_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // read-modify-write arithmetic for a hit
    always_comb
    begin
        old_cnt = valid_reg[stat_addr] ? stat_rdata[STAT_W-1:SUM_W] : '0;
        old_sum = valid_reg[stat_addr] ? stat_rdata[SUM_W-1:0] : '0;
        new_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;
        sum_ext = {old_sum[SUM_W-1], old_sum}
                + {{(SUM_W+1-POS_W){wt_reg[POS_W-1]}}, wt_reg};
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
        begin
            new_sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            new_sum = sum_ext[SUM_W-1:0];
        end
    end

    // center, width and divider operands for a read
    always_comb
    begin
        center_ext = {lo_reg[POS_W-1], lo_reg} + {hi_reg[POS_W-1], hi_reg};
        width_ext  = {hi_reg[POS_W-1], hi_reg} - {lo_reg[POS_W-1], lo_reg};
        if (mode_reg == MODE_DENS)
        begin
            num_s = {sum_reg, 16'h0000};
            den_s = {width_ext[POS_W], width_ext};
        end
        else
        begin
            num_s = {{(DIV_N_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
            den_s = {{(DIV_D_W-CNT_W){1'b0}}, cnt_reg};
        end
        div_num  = num_s[DIV_N_W-1] ? (~num_s + 1'b1) : num_s;
        div_den  = den_s[DIV_D_W-1] ? (~den_s + 1'b1) : den_s;
        quot_neg = num_s[DIV_N_W-1] ^ den_s[DIV_D_W-1];
        if (div_quot[DIV_N_W-1:SUM_W-1] != '0)
        begin
            quot_sat = quot_neg ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            quot_sat = quot_neg ? (~div_quot[SUM_W-1:0] + 1'b1) : div_quot[SUM_W-1:0];
        end
    end

    assign scan_hit = ($signed(lo_reg) < $signed(pos_reg))
                    && ($signed(pos_reg) < $signed(edge_rdata));

    // control sequencer
    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        wt_next         = wt_reg;
        idx_next        = idx_reg;
        dval_next       = 1'b0;
        didx_next       = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        bin_next        = bin_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_num_next    = res_num_reg;
        res_center_next = res_center_reg;
        res_cnt_next    = res_cnt_reg;
        res_sum_next    = res_sum_reg;
        res_val_next    = res_val_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_status_next   = m_status_reg;
        m_num_next      = m_num_reg;
        m_center_next   = m_center_reg;
        m_cnt_next      = m_cnt_reg;
        m_sum_next      = m_sum_reg;
        m_val_next      = m_val_reg;
        edge_we         = 1'b0;
        edge_addr       = slot_reg;
        edge_wdata      = pos_reg;
        stat_we         = 1'b0;
        stat_addr       = bin_reg;
        stat_wdata      = {new_cnt, new_sum};
        div_start       = 1'b0;
        s_tready        = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                s_tready   = 1'b1;
                edge_addr  = in_slot;
                edge_wdata = in_pos;
                stat_addr  = in_slot[BIN_W-1:0];
                if (s_tvalid)
                begin
                    slot_next       = in_slot;
                    pos_next        = in_pos;
                    wt_next         = in_wt;
                    res_status_next = STS_OK;
                    res_num_next    = '0;
                    res_center_next = '0;
                    res_cnt_next    = '0;
                    res_sum_next    = '0;
                    res_val_next    = '0;
                    case (in_req)
                        REQ_EDGE:
                        begin
                            if (in_slot <= SLOT_W'(NBINS))
                            begin
                                edge_we = 1'b1;
                            end
                            else
                            begin
                                res_status_next = STS_RANGE;
                            end
                            state_next = FSM_RESP;
                        end
                        REQ_SAMPLE:
                        begin
                            idx_next   = '0;
                            state_next = FSM_SCAN;
                        end
                        REQ_READ:
                        begin
                            if (in_slot < nb)
                            begin
                                state_next = FSM_RD_LO;
                            end
                            else
                            begin
                                res_status_next = STS_RANGE;
                                state_next      = FSM_RESP;
                            end
                        end
                        default:
                        begin
                            res_status_next = STS_RANGE;
                            state_next      = FSM_RESP;
                        end
                    endcase
                end
            end

            FSM_SCAN:
            begin
                // one edge read per cycle, compare against the previous edge
                edge_addr = (idx_reg > nb) ? nb : idx_reg;
                dval_next = (idx_reg <= nb);
                didx_next = idx_reg;
                idx_next  = (idx_reg > nb) ? idx_reg : idx_reg + 1'b1;
                if (dval_reg)
                begin
                    if (didx_reg == '0)
                    begin
                        lo_next = edge_rdata;
                    end
                    else if (scan_hit)
                    begin
                        bin_next   = BIN_W'(didx_reg - 1'b1);
                        dval_next  = 1'b0;
                        state_next = FSM_HIT_RD;
                    end
                    else
                    begin
                        lo_next = edge_rdata;
                        if (didx_reg == nb)
                        begin
                            dval_next       = 1'b0;
                            res_status_next = STS_MISS;
                            state_next      = FSM_RESP;
                        end
                    end
                end
            end

            FSM_HIT_RD:
            begin
                state_next = FSM_HIT_WB;
            end

            FSM_HIT_WB:
            begin
                stat_we             = 1'b1;
                valid_next[bin_reg] = 1'b1;
                res_num_next        = bin_reg;
                res_cnt_next        = new_cnt;
                res_sum_next        = new_sum;
                state_next          = FSM_RESP;
            end

            FSM_RD_LO:
            begin
                stat_addr  = slot_reg[BIN_W-1:0];
                edge_addr  = slot_reg + 1'b1;
                lo_next    = edge_rdata;
                cnt_next   = old_cnt;
                sum_next   = old_sum;
                state_next = FSM_RD_HI;
            end

            FSM_RD_HI:
            begin
                hi_next    = edge_rdata;
                state_next = FSM_CALC;
            end

            FSM_CALC:
            begin
                res_num_next    = slot_reg[BIN_W-1:0];
                res_center_next = center_ext[POS_W:1];
                res_cnt_next    = cnt_reg;
                res_sum_next    = sum_reg;
                state_next      = FSM_RESP;
                if (mode_reg == MODE_AVG)
                begin
                    if (cnt_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = FSM_DIV;
                    end
                end
                else if (mode_reg == MODE_DENS)
                begin
                    if (width_ext == '0)
                    begin
                        res_status_next = STS_ZERO_W;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = FSM_DIV;
                    end
                end
            end

            FSM_DIV:
            begin
                if (div_done)
                begin
                    res_val_next = quot_sat;
                    state_next   = FSM_RESP;
                end
            end

            FSM_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_num_next    = res_num_reg;
                    m_center_next = res_center_reg;
                    m_cnt_next    = res_cnt_reg;
                    m_sum_next    = res_sum_reg;
                    m_val_next    = res_val_reg;
                    state_next    = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            bins_reg    <= BINS_RESET;
            mode_reg    <= MODE_AVG;
            valid_reg   <= '0;
            dval_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bins_reg    <= bins_next;
            mode_reg    <= mode_next;
            valid_reg   <= valid_next;
            dval_reg    <= dval_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        pos_reg        <= pos_next;
        wt_reg         <= wt_next;
        didx_reg       <= didx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        bin_reg        <= bin_next;
        cnt_reg        <= cnt_next;
        sum_reg        <= sum_next;
        res_status_reg <= res_status_next;
        res_num_reg    <= res_num_next;
        res_center_reg <= res_center_next;
        res_cnt_reg    <= res_cnt_next;
        res_sum_reg    <= res_sum_next;
        res_val_reg    <= res_val_next;
        m_status_reg   <= m_status_next;
        m_num_reg      <= m_num_next;
        m_center_reg   <= m_center_next;
        m_cnt_reg      <= m_cnt_next;
        m_sum_reg      <= m_sum_next;
        m_val_reg      <= m_val_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_val_reg, m_sum_reg, m_cnt_reg, m_center_reg, m_num_reg};

endmodule

[sv/whist_ram.sv]
module whist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/whist_div.sv]
module whist_div
    import whist_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic [DIV_D_W:0]     rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   den_reg, den_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIV_D_W-1:0], quo_reg[DIV_N_W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff;
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
